FILE: hw/rtl/bgti_pkg.sv
// Package for the bilinear grid table interpolator.
// Table sizes, derived widths, action codes, status codes and register indexes.
// No dependencies.
package bgti_pkg;

   localparam int MAX_TEMPS = 32;
   localparam int MAX_PRESS = 32;
   localparam int MAXN      = (MAX_TEMPS > MAX_PRESS) ? MAX_TEMPS : MAX_PRESS;
   localparam int IW        = $clog2(MAXN);          // axis index width
   localparam int CW        = IW + 1;                // entry count width
   localparam int TA_W      = $clog2(MAX_TEMPS);
   localparam int PA_W      = $clog2(MAX_PRESS);
   localparam int GW        = $clog2(MAX_TEMPS * MAX_PRESS);

   localparam logic [2:0] ACT_WR_TEMP  = 3'd0;
   localparam logic [2:0] ACT_WR_PRESS = 3'd1;
   localparam logic [2:0] ACT_WR_GRID  = 3'd2;
   localparam logic [2:0] ACT_COMMIT   = 3'd3;
   localparam logic [2:0] ACT_QUERY    = 3'd4;

   localparam logic [2:0] ST_WRITE_OK  = 3'd0;
   localparam logic [2:0] ST_INTERP    = 3'd1;
   localparam logic [2:0] ST_FALLBACK  = 3'd2;
   localparam logic [2:0] ST_COMMIT_OK = 3'd3;
   localparam logic [2:0] ST_COMMIT_NO = 3'd4;
   localparam logic [2:0] ST_BAD_INDEX = 3'd5;

   localparam logic [1:0] CSR_TEMP_COUNT  = 2'd0;
   localparam logic [1:0] CSR_PRESS_COUNT = 2'd1;
   localparam logic [1:0] CSR_OP_PRESS    = 2'd2;
   localparam logic [1:0] CSR_FALLBACK    = 2'd3;

   localparam logic [16:0]        ONE_Q16  = 17'h10000;
   localparam logic signed [40:0] AXIS_MAX = 41'sd549755813887;
   localparam logic signed [40:0] AXIS_MIN = -41'sd549755813888;

endpackage

FILE: hw/rtl/bilinear_grid_table_interpolator.sv
// Top level of the bilinear grid table interpolator: axis and grid memories,
// binary-search sequencer, radix-2 fraction divider and bilinear blend.
// Depends on bgti_pkg.

// One transaction at a time. A commit sweeps both axis memories, reading one
// entry at a time. A query to a valid table runs two binary searches over the
// single-port axis memories, a 16-step restoring divider per axis, four grid
// reads and three multiply/add blends. The search probes and the divider steps
// are skipped for a query coordinate that falls outside its axis. The next
// transaction is accepted while a finished result waits in the output register.
module bilinear_grid_table_interpolator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_action,
   input  logic [4:0]          req_row_index,
   input  logic [4:0]          req_col_index,
   input  logic signed [39:0]  req_axis_value,
   input  logic signed [31:0]  req_grid_value,
   input  logic signed [39:0]  req_query_temp,
   input  logic signed [39:0]  req_query_gauge_press,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_result_value,
   output logic [2:0]          rsp_status,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [39:0]         csr_write_data
);
   import bgti_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_OUT, S_C_RD, S_C_D,
      S_Q_FIRST, S_Q_LAST, S_Q_LAST_D, S_Q_MID, S_Q_MID_D,
      S_Q_LO, S_Q_HI, S_Q_HI_D, S_DIV_SET, S_DIV,
      S_G0, S_G1, S_G2, S_G3, S_G4, S_BL_M, S_BL_A
   } state_type;

   state_type state_ff;

   // configuration
   logic [5:0]         temp_count_ff, press_count_ff;
   logic signed [39:0] op_press_ff;
   logic signed [31:0] fallback_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_count_ff  <= 6'd2;
         press_count_ff <= 6'd2;
         op_press_ff    <= 40'sd6640435200;
         fallback_ff    <= 32'sd65418035;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TEMP_COUNT:  temp_count_ff  <= csr_write_data[5:0];
            CSR_PRESS_COUNT: press_count_ff <= csr_write_data[5:0];
            CSR_OP_PRESS:    op_press_ff    <= $signed(csr_write_data);
            CSR_FALLBACK:    fallback_ff    <= $signed(csr_write_data[31:0]);
            default: ;
         endcase
      end
   end

   logic [CW-1:0] nt, np;
   always_comb begin
      if (temp_count_ff < 6'd2) nt = CW'(2);
      else if (32'(temp_count_ff) > 32'(MAX_TEMPS)) nt = CW'(MAX_TEMPS);
      else nt = CW'(temp_count_ff);
      if (press_count_ff < 6'd2) np = CW'(2);
      else if (32'(press_count_ff) > 32'(MAX_PRESS)) np = CW'(MAX_PRESS);
      else np = CW'(press_count_ff);
   end

   // datapath registers
   logic                sel_ff;          // 0 temperature axis, 1 pressure axis
   logic [CW-1:0]       k_ff;
   logic signed [39:0]  prev_ff;
   logic                ok_ff;
   logic                table_valid_ff;
   logic signed [39:0]  qt_ff, p_ff, a0_ff, alo_ff, ahi_ff;
   logic [IW-1:0]       lo_ff, hi_ff, ti_ff, pj_ff;
   logic [40:0]         rem_ff, d_ff;
   logic [15:0]         q_ff;
   logic [3:0]          dcnt_ff;
   logic [16:0]         ft_ff, fp_ff;
   logic signed [31:0]  g00_ff, g01_ff, g10_ff, g11_ff, r0_ff, r1_ff;
   logic signed [50:0]  prod_ff;
   logic [1:0]          bstep_ff;
   logic signed [31:0]  pend_value_ff, rsp_value_ff;
   logic [2:0]          pend_status_ff, rsp_status_ff;
   logic                rsp_valid_ff;

   logic accept;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // memories
   logic signed [39:0] temp_mem  [MAX_TEMPS];
   logic signed [39:0] press_mem [MAX_PRESS];
   logic signed [31:0] grid_mem  [MAX_TEMPS * MAX_PRESS];
   logic signed [39:0] t_rd_ff, p_rd_ff;
   logic signed [31:0] g_rd_ff;

   logic row_ok, col_ok, t_we, p_we, g_we;
   logic [IW-1:0] axaddr;
   logic [GW-1:0] g_waddr, g_base, g_raddr;

   assign row_ok  = 32'(req_row_index) < 32'(MAX_TEMPS);
   assign col_ok  = 32'(req_col_index) < 32'(MAX_PRESS);
   assign t_we    = accept && (req_action == ACT_WR_TEMP) && row_ok;
   assign p_we    = accept && (req_action == ACT_WR_PRESS) && col_ok;
   assign g_we    = accept && (req_action == ACT_WR_GRID) && row_ok && col_ok;
   assign g_waddr = GW'(GW'(req_row_index) * GW'(MAX_PRESS) + GW'(req_col_index));
   assign g_base  = GW'(GW'(ti_ff) * GW'(MAX_PRESS) + GW'(pj_ff));

   always_ff @(posedge clock) begin
      if (t_we) temp_mem[TA_W'(req_row_index)] <= req_axis_value;
      t_rd_ff <= temp_mem[TA_W'(axaddr)];
   end

   always_ff @(posedge clock) begin
      if (p_we) press_mem[PA_W'(req_col_index)] <= req_axis_value;
      p_rd_ff <= press_mem[PA_W'(axaddr)];
   end

   always_ff @(posedge clock) begin
      if (g_we) grid_mem[g_waddr] <= req_grid_value;
      g_rd_ff <= grid_mem[g_raddr];
   end

   // search and address logic
   logic signed [39:0] ard, vq;
   logic [CW-1:0]      n_cur;
   logic [IW:0]        lh_sum;
   logic [IW-1:0]      mid;

   assign ard    = sel_ff ? p_rd_ff : t_rd_ff;
   assign vq     = sel_ff ? p_ff : qt_ff;
   assign n_cur  = sel_ff ? np : nt;
   assign lh_sum = (IW+1)'(lo_ff) + (IW+1)'(hi_ff);
   assign mid    = lh_sum[IW:1];

   always_comb begin
      case (state_ff)
         S_C_RD:    axaddr = k_ff[IW-1:0];
         S_Q_LAST:  axaddr = IW'(n_cur - CW'(1));
         S_Q_MID:   axaddr = mid;
         S_Q_LO:    axaddr = lo_ff;
         S_Q_HI:    axaddr = IW'(lo_ff + IW'(1));
         default:   axaddr = '0;
      endcase
      case (state_ff)
         S_G1:    g_raddr = GW'(g_base + GW'(1));
         S_G2:    g_raddr = GW'(g_base + GW'(MAX_PRESS));
         S_G3:    g_raddr = GW'(g_base + GW'(MAX_PRESS + 1));
         default: g_raddr = g_base;
      endcase
   end

   // commit check
   logic ok_in;
   assign ok_in = ok_ff && !((k_ff != '0) && (ard <= prev_ff));

   // fraction setup and divider step
   logic signed [40:0] dd, nn, dn, numn;
   logic [41:0]        rem2;
   logic               rem_ge;
   always_comb begin
      dd = 41'(ahi_ff) - 41'(alo_ff);
      nn = 41'(vq) - 41'(alo_ff);
      if (dd < 0) begin
         dn   = -dd;
         numn = -nn;
      end else begin
         dn   = dd;
         numn = nn;
      end
      rem2   = {rem_ff, 1'b0};
      rem_ge = rem2 >= {1'b0, d_ff};
   end

   // query pressure, saturated
   logic signed [40:0] psum, psat;
   always_comb begin
      psum = 41'(req_query_gauge_press) + 41'(op_press_ff);
      if (psum > AXIS_MAX) psat = AXIS_MAX;
      else if (psum < AXIS_MIN) psat = AXIS_MIN;
      else psat = psum;
   end

   // blend: a + round((f * (b - a)) / 65536)
   logic signed [31:0] ba, bb;
   logic [16:0]        bf;
   logic signed [32:0] bdiff;
   logic signed [50:0] bprod, rsum;
   logic signed [34:0] rsh;
   logic signed [31:0] blend_res;
   always_comb begin
      case (bstep_ff)
         2'd0:    begin ba = g00_ff; bb = g01_ff; bf = fp_ff; end
         2'd1:    begin ba = g10_ff; bb = g11_ff; bf = fp_ff; end
         default: begin ba = r0_ff;  bb = r1_ff;  bf = ft_ff; end
      endcase
      bdiff     = 33'(bb) - 33'(ba);
      bprod     = $signed({1'b0, bf}) * bdiff;
      rsum      = prod_ff + 51'sd32768;
      rsh       = rsum[50:16];
      blend_res = 32'(ba + rsh);
   end

   // axis finish: fraction done for the current axis
   logic        fin;
   logic [16:0] fval;
   always_comb begin
      fin  = 1'b0;
      fval = '0;
      if (state_ff == S_DIV_SET) begin
         if (dn == 0 || numn <= 0) begin
            fin = 1'b1;
         end else if (numn >= dn) begin
            fin  = 1'b1;
            fval = ONE_Q16;
         end
      end else if (state_ff == S_DIV && dcnt_ff == 4'd15) begin
         fin  = 1'b1;
         fval = {1'b0, q_ff[14:0], rem_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         table_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pend_value_ff <= '0;
                  state_ff      <= S_OUT;
                  case (req_action)
                     ACT_WR_TEMP:  pend_status_ff <= row_ok ? ST_WRITE_OK : ST_BAD_INDEX;
                     ACT_WR_PRESS: pend_status_ff <= col_ok ? ST_WRITE_OK : ST_BAD_INDEX;
                     ACT_WR_GRID:  pend_status_ff <= (row_ok && col_ok) ? ST_WRITE_OK
                                                                        : ST_BAD_INDEX;
                     ACT_COMMIT: begin
                        sel_ff   <= 1'b0;
                        k_ff     <= '0;
                        ok_ff    <= 1'b1;
                        state_ff <= S_C_RD;
                     end
                     ACT_QUERY: begin
                        if (!table_valid_ff) begin
                           pend_value_ff  <= fallback_ff;
                           pend_status_ff <= ST_FALLBACK;
                        end else begin
                           qt_ff    <= req_query_temp;
                           p_ff     <= 40'(psat);
                           sel_ff   <= 1'b0;
                           state_ff <= S_Q_FIRST;
                        end
                     end
                     default: pend_status_ff <= ST_BAD_INDEX;
                  endcase
               end
            end
            S_C_RD: state_ff <= S_C_D;
            S_C_D: begin
               prev_ff <= ard;
               ok_ff   <= ok_in;
               if (k_ff + CW'(1) == n_cur) begin
                  if (!sel_ff) begin
                     sel_ff   <= 1'b1;
                     k_ff     <= '0;
                     state_ff <= S_C_RD;
                  end else begin
                     table_valid_ff <= ok_in;
                     pend_value_ff  <= '0;
                     pend_status_ff <= ok_in ? ST_COMMIT_OK : ST_COMMIT_NO;
                     state_ff       <= S_OUT;
                  end
               end else begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= S_C_RD;
               end
            end
            S_Q_FIRST: state_ff <= S_Q_LAST;
            S_Q_LAST: begin
               a0_ff    <= ard;
               state_ff <= S_Q_LAST_D;
            end
            S_Q_LAST_D: begin
               if (vq <= a0_ff) begin
                  lo_ff    <= '0;
                  state_ff <= S_Q_LO;
               end else if (vq >= ard) begin
                  lo_ff    <= IW'(n_cur - CW'(2));
                  state_ff <= S_Q_LO;
               end else begin
                  lo_ff    <= '0;
                  hi_ff    <= IW'(n_cur - CW'(1));
                  state_ff <= S_Q_MID;
               end
            end
            S_Q_MID: state_ff <= (hi_ff - lo_ff > IW'(1)) ? S_Q_MID_D : S_Q_LO;
            S_Q_MID_D: begin
               if (ard <= vq) lo_ff <= mid;
               else hi_ff <= mid;
               state_ff <= S_Q_MID;
            end
            S_Q_LO: state_ff <= S_Q_HI;
            S_Q_HI: begin
               alo_ff   <= ard;
               state_ff <= S_Q_HI_D;
            end
            S_Q_HI_D: begin
               ahi_ff   <= ard;
               state_ff <= S_DIV_SET;
            end
            S_DIV_SET: begin
               rem_ff   <= numn;
               d_ff     <= dn;
               q_ff     <= '0;
               dcnt_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= rem_ge ? 41'(rem2 - {1'b0, d_ff}) : rem2[40:0];
               q_ff    <= {q_ff[14:0], rem_ge};
               dcnt_ff <= dcnt_ff + 4'd1;
            end
            S_G0: state_ff <= S_G1;
            S_G1: begin g00_ff <= g_rd_ff; state_ff <= S_G2; end
            S_G2: begin g01_ff <= g_rd_ff; state_ff <= S_G3; end
            S_G3: begin g10_ff <= g_rd_ff; state_ff <= S_G4; end
            S_G4: begin
               g11_ff   <= g_rd_ff;
               bstep_ff <= 2'd0;
               state_ff <= S_BL_M;
            end
            S_BL_M: begin
               prod_ff  <= bprod;
               state_ff <= S_BL_A;
            end
            S_BL_A: begin
               case (bstep_ff)
                  2'd0: begin
                     r0_ff    <= blend_res;
                     bstep_ff <= 2'd1;
                     state_ff <= S_BL_M;
                  end
                  2'd1: begin
                     r1_ff    <= blend_res;
                     bstep_ff <= 2'd2;
                     state_ff <= S_BL_M;
                  end
                  default: begin
                     pend_value_ff  <= blend_res;
                     pend_status_ff <= ST_INTERP;
                     state_ff       <= S_OUT;
                  end
               endcase
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= pend_value_ff;
                  rsp_status_ff <= pend_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // fraction complete: store it, move to the next axis or the grid reads
         if (fin) begin
            if (!sel_ff) begin
               ft_ff    <= fval;
               ti_ff    <= lo_ff;
               sel_ff   <= 1'b1;
               state_ff <= S_Q_FIRST;
            end else begin
               fp_ff    <= fval;
               pj_ff    <= lo_ff;
               state_ff <= S_G0;
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

FILE: hw/rtl/bgti_checker.sv
// Port-level checker for the bilinear grid table interpolator, with its bind.
// Depends on bgti_pkg and bilinear_grid_table_interpolator.
module bgti_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_result_value,
   input logic [2:0]         rsp_status
);
   import bgti_pkg::*;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                  && $stable(rsp_status))
      else $error("result transaction changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_BAD_INDEX)
      else $error("status code out of range");

   // only query answers carry a value
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_INTERP && rsp_status != ST_FALLBACK
      |-> rsp_result_value == 32'sd0)
      else $error("non-query result with nonzero value");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind bilinear_grid_table_interpolator bgti_checker u_bgti_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status)
);
